FILE: rtl/ftc_pkg.sv
// ----------------------------------------------------------------------------
// ftc_pkg
// Shared types and constants for the FAT timestamp converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ftc_pkg;

  typedef struct packed {
    logic               kind;
    logic [15:0]        date_word;
    logic [15:0]        time_word;
    logic [7:0]         centiseconds_in;
    logic signed [39:0] unix_seconds_in;
  } ftc_in_t;

  typedef struct packed {
    logic [32:0] unix_seconds_out;
    logic [15:0] date_out;
    logic [15:0] time_out;
    logic [6:0]  centiseconds_out;
    logic [2:0]  status;
  } ftc_out_t;

  // conversion direction
  localparam logic KindToUnix = 1'b0;
  localparam logic KindToFat  = 1'b1;

  // result status codes
  localparam logic [2:0] StatusOk      = 3'd0;
  localparam logic [2:0] StatusBadDate = 3'd1;
  localparam logic [2:0] StatusBadTime = 3'd2;
  localparam logic [2:0] StatusBadCsec = 3'd3;
  localparam logic [2:0] StatusClamped = 3'd4;

  localparam int unsigned ZoneW = 17;

  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [16:0] SecsPerHour = 17'd3600;
  localparam logic [31:0] FatBaseSecs = 32'd315532800;  // 1970-01-01 to 1980-01-01
  localparam logic [31:0] SpanMaxSecs = 32'd4039372799; // last second of 2107

  // reciprocals: exact floor division over the value ranges used here
  localparam logic [25:0] DayRecip  = 26'd50903317;  // x / 675, x < 2^25
  localparam int unsigned DayShift  = 35;
  localparam logic [17:0] YearRecip = 18'd183735;    // x / 1461
  localparam int unsigned YearShift = 28;
  localparam logic [16:0] HourRecip = 17'd74566;     // x / 3600
  localparam int unsigned HourShift = 28;
  localparam logic [12:0] MinRecip  = 13'd4370;      // x / 60
  localparam int unsigned MinShift  = 18;

  // day of year at which a month starts, non-leap
  function automatic logic [8:0] month_start(input logic [3:0] month);
    logic [8:0] res;
    case (month)
      4'd2:    res = 9'd31;
      4'd3:    res = 9'd59;
      4'd4:    res = 9'd90;
      4'd5:    res = 9'd120;
      4'd6:    res = 9'd151;
      4'd7:    res = 9'd181;
      4'd8:    res = 9'd212;
      4'd9:    res = 9'd243;
      4'd10:   res = 9'd273;
      4'd11:   res = 9'd304;
      4'd12:   res = 9'd334;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fat_timestamp_converter_unit.sv
// ----------------------------------------------------------------------------
// fat_timestamp_converter_unit
// Converts between packed FAT date/time words and Unix seconds.
// ----------------------------------------------------------------------------
//  port group   dir  handshake                payload
//  in_*         in   in_valid_i / in_stall_o  ftc_in_t  in_item_i
//  out_*        out  out_valid_o / out_stall_i ftc_out_t out_item_o
//  cfg_*        in   cfg_we_i                 zone offset, 17 bit signed
//
//  Eight-stage pipeline (input register, six work stages, result register).
//  One item per cycle while out_stall_i is low; a result is valid once it reaches the result register.
//  Depth is set by the reciprocal multipliers for /86400, /1461, /3600, /60.
//  Each stage holds while the one after it is full and stalled, so bubbles
//  are squeezed out. Reset clears the stage valid bits and the zone offset.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_timestamp_converter_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic signed [ftc_pkg::ZoneW-1:0]   cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire ftc_pkg::ftc_in_t                   in_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output ftc_pkg::ftc_out_t                       out_item_o
);

  localparam int unsigned NumStages = 8;
  localparam int unsigned LastStage = NumStages - 1;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [32:0] unix;
  } ftc_side_t;

  // zone offset register
  logic signed [ftc_pkg::ZoneW-1:0] zone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= '0;
    end else if (cfg_we_i) begin
      zone_q <= cfg_wdata_i;
    end
  end

  // pipeline flow control
  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   ready;

  always_comb begin
    ready[NumStages] = !out_stall_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k + 1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_q[k - 1];
        end
      end
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[LastStage];

  // input register
  ftc_pkg::ftc_in_t in_q;

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      in_q <= in_item_i;
    end
  end

  // FAT to Unix, stage A: validate, day count and seconds of day
  logic [4:0]  day_in, twosec_in, hour_in;
  logic [3:0]  month_in;
  logic [6:0]  year_in;
  logic [5:0]  min_in;
  logic [7:0]  leaps_inc;
  logic        leap_adj;
  logic [2:0]  status_a_d;
  logic [15:0] days_a_d;
  logic [16:0] sod_a_d;

  assign day_in    = in_q.date_word[4:0];
  assign month_in  = in_q.date_word[8:5];
  assign year_in   = in_q.date_word[15:9];
  assign twosec_in = in_q.time_word[4:0];
  assign min_in    = in_q.time_word[10:5];
  assign hour_in   = in_q.time_word[15:11];
  assign leaps_inc = {1'b0, year_in} + 8'd3;
  assign leap_adj  = (year_in[1:0] == 2'b00) && (month_in > 4'd2);

  always_comb begin
    if (day_in == 5'd0 || month_in == 4'd0 || month_in > 4'd12) begin
      status_a_d = ftc_pkg::StatusBadDate;
    end else if (hour_in > 5'd23 || min_in > 6'd59 || twosec_in > 5'd29) begin
      status_a_d = ftc_pkg::StatusBadTime;
    end else if (in_q.centiseconds_in > 8'd199) begin
      status_a_d = ftc_pkg::StatusBadCsec;
    end else begin
      status_a_d = ftc_pkg::StatusOk;
    end
  end

  assign days_a_d = 16'(year_in) * 16'd365 + 16'(leaps_inc[7:2])
                  + 16'(ftc_pkg::month_start(month_in)) + 16'(leap_adj)
                  + 16'(day_in) - 16'd1;
  assign sod_a_d  = 17'(hour_in) * ftc_pkg::SecsPerHour + 17'(min_in) * 17'd60
                  + 17'({twosec_in, 1'b0}) + 17'(in_q.centiseconds_in >= 8'd100);

  logic        kind_a_q, kind_b_q;
  logic [2:0]  status_a_q, status_b_q;
  logic [15:0] days_a_q;
  logic [16:0] sod_a_q, sod_b_q;
  logic [32:0] prod_b_q;
  logic [34:0] sum_c;
  ftc_side_t   side_q [3:6];

  // stage C: add time of day, epoch shift and zone offset
  assign sum_c = 35'(prod_b_q) + 35'(sod_b_q) + 35'(ftc_pkg::FatBaseSecs) + 35'(zone_q);

  always_ff @(posedge clk_i) begin
    if (ready[1]) begin
      kind_a_q   <= in_q.kind;
      status_a_q <= status_a_d;
      days_a_q   <= days_a_d;
      sod_a_q    <= sod_a_d;
    end
    if (ready[2]) begin
      kind_b_q   <= kind_a_q;
      status_b_q <= status_a_q;
      prod_b_q   <= 33'(days_a_q) * 33'(ftc_pkg::SecsPerDay);
      sod_b_q    <= sod_a_q;
    end
    if (ready[3]) begin
      side_q[3].kind   <= kind_b_q;
      side_q[3].status <= status_b_q;
      side_q[3].unix   <= (status_b_q == ftc_pkg::StatusOk) ? sum_c[32:0] : '0;
    end
    for (int k = 4; k <= 6; k++) begin
      if (ready[k]) begin
        side_q[k] <= side_q[k - 1];
      end
    end
  end

  // Unix to FAT datapath, stages A through F
  logic [15:0] fat_date, fat_time;
  logic [6:0]  fat_csec;
  logic        fat_clamp;

  ftc_to_fat u_to_fat (
    .clk_i      (clk_i),
    .stage_en_i (ready[6:1]),
    .unix_i     (in_q.unix_seconds_in),
    .zone_i     (zone_q),
    .date_o     (fat_date),
    .time_o     (fat_time),
    .csec_o     (fat_csec),
    .clamp_o    (fat_clamp)
  );

  // result register
  ftc_pkg::ftc_out_t out_d, out_q;

  always_comb begin
    out_d = '0;
    if (side_q[6].kind == ftc_pkg::KindToFat) begin
      out_d.date_out         = fat_date;
      out_d.time_out         = fat_time;
      out_d.centiseconds_out = fat_csec;
      out_d.status           = fat_clamp ? ftc_pkg::StatusClamped : ftc_pkg::StatusOk;
    end else begin
      out_d.unix_seconds_out = side_q[6].unix;
      out_d.status           = side_q[6].status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[LastStage]) begin
      out_q <= out_d;
    end
  end

  assign out_item_o = out_q;

`ifndef SYNTHESIS
  // input can only back up when every stage holds an item
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled with a free pipeline stage");

  // invalid FAT input yields zero Unix seconds and a zero FAT date
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == ftc_pkg::StatusBadDate ||
                    out_item_o.status == ftc_pkg::StatusBadTime ||
                    out_item_o.status == ftc_pkg::StatusBadCsec)
    |-> out_item_o.unix_seconds_out == 33'd0 && out_item_o.date_out == 16'd0)
    else $error("nonzero result on invalid input");

  // a clamp lands on the first or the last representable day
  a_clamp_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ftc_pkg::StatusClamped
    |-> out_item_o.date_out == {7'd0, 4'd1, 5'd1} ||
        out_item_o.date_out == {7'd127, 4'd12, 5'd31})
    else $error("clamped result off the range edge");

  // produced FAT words are well formed
  a_fat_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.date_out != 16'd0
    |-> out_item_o.date_out[4:0] != 5'd0 && out_item_o.date_out[8:5] != 4'd0 &&
        out_item_o.date_out[8:5] <= 4'd12 && out_item_o.time_out[4:0] <= 5'd29 &&
        out_item_o.time_out[10:5] <= 6'd59 && out_item_o.time_out[15:11] <= 5'd23)
    else $error("malformed FAT date or time word");
`endif

endmodule

`default_nettype wire

FILE: rtl/ftc_to_fat.sv
// ----------------------------------------------------------------------------
// ftc_to_fat
// Six-stage Unix seconds to packed FAT date/time datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ftc_to_fat (
  input  wire logic                        clk_i,
  input  wire logic [5:0]                  stage_en_i,
  input  wire logic signed [39:0]          unix_i,
  input  wire logic signed [ftc_pkg::ZoneW-1:0] zone_i,
  output logic [15:0]                      date_o,
  output logic [15:0]                      time_o,
  output logic [6:0]                       csec_o,
  output logic                             clamp_o
);

  // stage A: shift into FAT epoch and clamp
  logic [41:0] diff;
  logic [31:0] t_a_d, t_a_q;
  logic        clamp_a_d, clamp_a_q;

  assign diff = 42'(unix_i) - 42'(ftc_pkg::FatBaseSecs) - 42'(zone_i);

  always_comb begin
    t_a_d     = diff[31:0];
    clamp_a_d = 1'b0;
    if (diff[41]) begin
      t_a_d     = '0;
      clamp_a_d = 1'b1;
    end else if (diff[40:0] > 41'(ftc_pkg::SpanMaxSecs)) begin
      t_a_d     = ftc_pkg::SpanMaxSecs;
      clamp_a_d = 1'b1;
    end
  end

  // stage B: day count
  logic [50:0] day_prod;
  logic [15:0] days_b_q;
  logic [31:0] t_b_q;
  logic        clamp_b_q;

  assign day_prod = 51'(t_a_q[31:7]) * 51'(ftc_pkg::DayRecip);

  // stage C: seconds of day and year
  logic [32:0] day_secs;
  logic [31:0] rem_full;
  logic [35:0] year_prod;
  logic [16:0] rem_c_q;
  logic [6:0]  year_c_q;
  logic [15:0] days_c_q;
  logic        odd_c_q, clamp_c_q;

  assign day_secs  = 33'(days_b_q) * 33'(ftc_pkg::SecsPerDay);
  assign rem_full  = t_b_q - day_secs[31:0];
  assign year_prod = 36'({days_b_q, 2'b00}) * 36'(ftc_pkg::YearRecip);

  // stage D: day of year and hour
  logic [7:0]  leaps_inc;
  logic [15:0] doy_full;
  logic [33:0] hour_prod;
  logic [8:0]  doy_d_q;
  logic [4:0]  hour_d_q;
  logic [16:0] rem_d_q;
  logic [6:0]  year_d_q;
  logic        odd_d_q, clamp_d_q;

  assign leaps_inc = {1'b0, year_c_q} + 8'd3;
  assign doy_full  = days_c_q - 16'(year_c_q) * 16'd365 - 16'(leaps_inc[7:2]);
  assign hour_prod = 34'(rem_c_q) * 34'(ftc_pkg::HourRecip);

  // stage E: month, day of month, seconds within the hour
  logic        leap_e;
  logic [3:0]  month_e;
  logic [9:0]  mstart_e;
  logic [9:0]  mday_full;
  logic [16:0] rem2_full;
  logic [3:0]  month_e_q;
  logic [4:0]  day_e_q;
  logic [4:0]  hour_e_q;
  logic [6:0]  year_e_q;
  logic [11:0] rem2_e_q;
  logic        odd_e_q, clamp_e_q;

  assign leap_e = (year_d_q[1:0] == 2'b00);

  always_comb begin
    month_e = 4'd12;
    for (int m = 11; m >= 1; m--) begin
      if (10'(doy_d_q) < 10'(ftc_pkg::month_start(4'(m + 1))) + 10'(leap_e && (m >= 2))) begin
        month_e = 4'(m);
      end
    end
  end

  assign mstart_e  = 10'(ftc_pkg::month_start(month_e)) + 10'(leap_e && (month_e >= 4'd3));
  assign mday_full = 10'(doy_d_q) - mstart_e + 10'd1;
  assign rem2_full = rem_d_q - 17'(hour_d_q) * ftc_pkg::SecsPerHour;

  // stage F: minute
  logic [24:0] min_prod;
  logic [5:0]  min_f_q;
  logic [11:0] rem2_f_q;
  logic [3:0]  month_f_q;
  logic [4:0]  day_f_q;
  logic [4:0]  hour_f_q;
  logic [6:0]  year_f_q;
  logic        odd_f_q, clamp_f_q;

  assign min_prod = 25'(rem2_e_q) * 25'(ftc_pkg::MinRecip);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      t_a_q     <= t_a_d;
      clamp_a_q <= clamp_a_d;
    end
    if (stage_en_i[1]) begin
      days_b_q  <= day_prod[50:35];
      t_b_q     <= t_a_q;
      clamp_b_q <= clamp_a_q;
    end
    if (stage_en_i[2]) begin
      rem_c_q   <= rem_full[16:0];
      year_c_q  <= year_prod[34:28];
      days_c_q  <= days_b_q;
      odd_c_q   <= t_b_q[0];
      clamp_c_q <= clamp_b_q;
    end
    if (stage_en_i[3]) begin
      doy_d_q   <= doy_full[8:0];
      hour_d_q  <= hour_prod[32:28];
      rem_d_q   <= rem_c_q;
      year_d_q  <= year_c_q;
      odd_d_q   <= odd_c_q;
      clamp_d_q <= clamp_c_q;
    end
    if (stage_en_i[4]) begin
      month_e_q <= month_e;
      day_e_q   <= mday_full[4:0];
      hour_e_q  <= hour_d_q;
      year_e_q  <= year_d_q;
      rem2_e_q  <= rem2_full[11:0];
      odd_e_q   <= odd_d_q;
      clamp_e_q <= clamp_d_q;
    end
    if (stage_en_i[5]) begin
      min_f_q   <= min_prod[23:18];
      rem2_f_q  <= rem2_e_q;
      month_f_q <= month_e_q;
      day_f_q   <= day_e_q;
      hour_f_q  <= hour_e_q;
      year_f_q  <= year_e_q;
      odd_f_q   <= odd_e_q;
      clamp_f_q <= clamp_e_q;
    end
  end

  // seconds within the minute, then pack
  logic [11:0] sec_full;

  assign sec_full = rem2_f_q - 12'(min_f_q) * 12'd60;
  assign date_o   = {year_f_q, month_f_q, day_f_q};
  assign time_o   = {hour_f_q, min_f_q, sec_full[5:1]};
  assign csec_o   = odd_f_q ? 7'd100 : 7'd0;
  assign clamp_o  = clamp_f_q;

endmodule

`default_nettype wire
